[sv/fccw_pkg.sv]
package fccw_pkg;

  localparam int CLUSTER_W = 28;
  localparam int ADDR_W    = 32;
  localparam int WORD_W    = 32;
  localparam int BYTES_W   = 3;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Stream packing
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 96;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Input kinds carried in tuser
  localparam logic OP_START    = 1'b0;
  localparam logic OP_RESPONSE = 1'b1;

  // FAT type codes; the unused code behaves as FAT12
  localparam logic [1:0] FAT_TYPE_12 = 2'd0;
  localparam logic [1:0] FAT_TYPE_16 = 2'd1;
  localparam logic [1:0] FAT_TYPE_32 = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAT_TYPE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_SECTOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_CLUST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_SECTORS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_START        = 3'd4;

  // Register reset values
  localparam logic [1:0]  RST_FAT_TYPE          = FAT_TYPE_32;
  localparam logic [12:0] RST_BYTES_PER_SECTOR  = 13'd512;
  localparam logic [7:0]  RST_SECTORS_PER_CLUST = 8'd1;
  localparam logic [15:0] RST_RESERVED_SECTORS  = 16'd32;
  localparam logic [31:0] RST_DATA_START        = 32'd0;
  localparam logic [31:0] RST_FAT_BASE          = 32'd16384;

  // Entry masks and bad-cluster thresholds
  localparam logic [CLUSTER_W-1:0] MASK_FAT12 = 28'h0000FFF;
  localparam logic [CLUSTER_W-1:0] MASK_FAT16 = 28'h000FFFF;
  localparam logic [CLUSTER_W-1:0] BAD_FAT32  = 28'hFFFFFF7;
  localparam logic [CLUSTER_W-1:0] BAD_FAT16  = 28'h000FFF7;
  localparam logic [CLUSTER_W-1:0] BAD_FAT12  = 28'h0000FF7;
  localparam logic [CLUSTER_W-1:0] MIN_CLUSTER = 28'd2;

  localparam logic [BYTES_W-1:0] ENTRY_BYTES_WIDE   = 3'd4;
  localparam logic [BYTES_W-1:0] ENTRY_BYTES_NARROW = 3'd2;

  // Configuration as seen by front and back
  typedef struct packed {
    logic [1:0]        fat_type;
    logic [ADDR_W-1:0] fat_base;
    logic [7:0]        sectors_per_cluster;
    logic [ADDR_W-1:0] data_start;
  } cfg_t;

  // One classified item waiting for address generation
  typedef struct packed {
    logic                 chain_end;
    logic [CLUSTER_W-1:0] cluster;
  } q_entry_t;

endpackage

[sv/fccw_front.sv]
module fccw_front (
  input  logic                         clk,
  input  logic                         rst,
  input  fccw_pkg::cfg_t               cfg,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [fccw_pkg::S_TDATA_W-1:0] s_tdata,  // start_cluster, fat_word
  input  logic                         s_tuser,    // op
  input  logic                         q_full,
  output logic                         q_push,
  output fccw_pkg::q_entry_t           q_entry
);
  import fccw_pkg::*;

  logic [CLUSTER_W-1:0] held_cluster;
  logic                 chain_active;

  logic [CLUSTER_W-1:0] start_cluster;
  logic [WORD_W-1:0]    fat_word;
  logic [CLUSTER_W-1:0] next_cluster;
  logic [CLUSTER_W-1:0] bad_value;
  logic                 next_ok;
  logic                 accept;

  assign start_cluster = s_tdata[CLUSTER_W-1:0];
  assign fat_word      = s_tdata[CLUSTER_W+WORD_W-1:CLUSTER_W];
  assign s_tready      = !q_full;
  assign accept        = s_tvalid && s_tready;

  // Extract the next cluster from the raw FAT word
  always_comb begin
    case (cfg.fat_type)
      FAT_TYPE_32: begin
        next_cluster = fat_word[CLUSTER_W-1:0];
        bad_value    = BAD_FAT32;
      end
      FAT_TYPE_16: begin
        next_cluster = fat_word[CLUSTER_W-1:0] & MASK_FAT16;
        bad_value    = BAD_FAT16;
      end
      default: begin
        // odd clusters sit in the upper 12 bits of the byte pair
        if (held_cluster[0]) begin
          next_cluster = {16'd0, fat_word[15:4]};
        end else begin
          next_cluster = fat_word[CLUSTER_W-1:0] & MASK_FAT12;
        end
        bad_value = BAD_FAT12;
      end
    endcase
  end

  assign next_ok = (next_cluster >= MIN_CLUSTER) && (next_cluster < bad_value);

  // Classify the item for the back end
  always_comb begin
    q_push  = accept;
    q_entry = '0;
    if (s_tuser == OP_START) begin
      q_entry.cluster = start_cluster;
    end else if (!chain_active) begin
      q_entry.chain_end = 1'b1;
    end else begin
      q_entry.cluster   = next_cluster;
      q_entry.chain_end = !next_ok;
    end
  end

  // Chain state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_cluster <= '0;
      chain_active <= 1'b0;
    end else if (accept) begin
      if (s_tuser == OP_START) begin
        held_cluster <= start_cluster;
        chain_active <= 1'b1;
      end else if (chain_active) begin
        if (next_ok) begin
          held_cluster <= next_cluster;
        end else begin
          chain_active <= 1'b0;
        end
      end
    end
  end

endmodule

[sv/fccw_queue.sv]
module fccw_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  fccw_pkg::q_entry_t wr_entry,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output fccw_pkg::q_entry_t rd_entry
);
  import fccw_pkg::*;

  q_entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_entry  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/fccw_back.sv]
module fccw_back (
  input  logic                           clk,
  input  logic                           rst,
  input  fccw_pkg::cfg_t                 cfg,
  input  logic                           q_valid,
  input  fccw_pkg::q_entry_t             q_entry,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // current_cluster_out, fat_byte_address, entry_size, data_sector
  output logic [fccw_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast   // chain_end
);
  import fccw_pkg::*;

  logic [ADDR_W-1:0]  c32;
  logic [ADDR_W-1:0]  entry_off;
  logic [BYTES_W-1:0] entry_bytes;
  logic [ADDR_W-1:0]  rel_cluster;
  logic [ADDR_W-1:0]  sector_prod;
  logic [ADDR_W-1:0]  fat_addr;
  logic [ADDR_W-1:0]  sector;

  logic [CLUSTER_W-1:0] out_cluster;
  logic [ADDR_W-1:0]    out_addr;
  logic [BYTES_W-1:0]   out_bytes;
  logic [ADDR_W-1:0]    out_sector;

  assign q_pop = q_valid && (!m_tvalid || m_tready);
  assign c32   = {{(ADDR_W-CLUSTER_W){1'b0}}, q_entry.cluster};

  // FAT entry offset and width
  always_comb begin
    case (cfg.fat_type)
      FAT_TYPE_32: begin
        entry_off   = {c32[ADDR_W-3:0], 2'b00};
        entry_bytes = ENTRY_BYTES_WIDE;
      end
      FAT_TYPE_16: begin
        entry_off   = {c32[ADDR_W-2:0], 1'b0};
        entry_bytes = ENTRY_BYTES_NARROW;
      end
      default: begin
        entry_off   = c32 + (c32 >> 1);
        entry_bytes = ENTRY_BYTES_NARROW;
      end
    endcase
  end

  // Addresses, wrapping at 32 bits
  assign fat_addr    = cfg.fat_base + entry_off;
  assign rel_cluster = c32 - ADDR_W'(2);
  assign sector_prod = rel_cluster * ADDR_W'(cfg.sectors_per_cluster);
  assign sector      = sector_prod + cfg.data_start;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_cluster <= q_entry.cluster;
      m_tlast     <= q_entry.chain_end;
      if (q_entry.chain_end) begin
        out_addr   <= '0;
        out_bytes  <= '0;
        out_sector <= '0;
      end else begin
        out_addr   <= fat_addr;
        out_bytes  <= entry_bytes;
        out_sector <= sector;
      end
    end
  end

  assign m_tdata = {1'b0, out_sector, out_bytes, out_addr, out_cluster};

endmodule

[sv/fat_cluster_chain_walker_core.sv]
// FAT cluster chain walker. A start item (tuser 0) loads a first cluster and
// answers with that cluster's FAT entry byte address and width and its first
// data sector; a response item (tuser 1) carries the FAT word read from that
// address, and the block answers with the next cluster's addresses or, at a
// free, reserved, bad or end-of-chain value, with tlast set and the address
// fields zero. Exactly one result per item. The block takes one item per
// cycle while the queue is not full; an accepted item passes through the
// queue and then the output register. The front resolves the next cluster
// against the held one in the accept cycle, a two-entry queue decouples it
// from the back, whose multiply of cluster by sectors per cluster sets the
// back's path, and an output register holds the result while the sink
// stalls. Registers must be written through cfg_we while the block is idle;
// the block does not enforce this. The FAT base (reserved sectors times
// bytes per sector) is registered from them. No clearing pass after reset.
module fat_cluster_chain_walker_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fccw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fccw_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fccw_pkg::S_TDATA_W-1:0] s_tdata,  // start_cluster, fat_word
  input  logic                           s_tuser,  // op
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // current_cluster_out, fat_byte_address, entry_size, data_sector
  output logic [fccw_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast   // chain_end
);
  import fccw_pkg::*;

  logic [1:0]  fat_type;
  logic [12:0] bytes_per_sector;
  logic [7:0]  sectors_per_cluster;
  logic [15:0] reserved_sectors;
  logic [31:0] data_start;
  logic [31:0] fat_base;
  logic [28:0] base_prod;

  cfg_t     cfg;
  logic     q_full;
  logic     q_push;
  q_entry_t q_wr;
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_rd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fat_type            <= RST_FAT_TYPE;
      bytes_per_sector    <= RST_BYTES_PER_SECTOR;
      sectors_per_cluster <= RST_SECTORS_PER_CLUST;
      reserved_sectors    <= RST_RESERVED_SECTORS;
      data_start          <= RST_DATA_START;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FAT_TYPE:          fat_type            <= cfg_data[1:0];
        REG_BYTES_PER_SECTOR:  bytes_per_sector    <= cfg_data[12:0];
        REG_SECTORS_PER_CLUST: sectors_per_cluster <= cfg_data[7:0];
        REG_RESERVED_SECTORS:  reserved_sectors    <= cfg_data[15:0];
        REG_DATA_START:        data_start          <= cfg_data;
        default: ;
      endcase
    end
  end

  // FAT base byte offset, recomputed every cycle
  assign base_prod = 29'(reserved_sectors) * 29'(bytes_per_sector);

  always_ff @(posedge clk) begin
    if (rst) begin
      fat_base <= RST_FAT_BASE;
    end else begin
      fat_base <= {3'b000, base_prod};
    end
  end

  assign cfg.fat_type            = fat_type;
  assign cfg.fat_base            = fat_base;
  assign cfg.sectors_per_cluster = sectors_per_cluster;
  assign cfg.data_start          = data_start;

  fccw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_wr)
  );

  fccw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_entry  (q_wr),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_entry  (q_rd)
  );

  fccw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_entry  (q_rd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[sv/fccw_checker.sv]
module fccw_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [fccw_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import fccw_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Chain end carries no addresses
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[94:28] == '0)
    else $error("address fields nonzero at chain end");

  // Live result reads two or four bytes
  a_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[62:60] == ENTRY_BYTES_WIDE ||
                             m_tdata[62:60] == ENTRY_BYTES_NARROW)
    else $error("bad FAT entry width");

  // Nothing comes out the cycle after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // An item accepted while the output holds no result makes the output valid
  a_flow: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
    else $error("accepted item did not reach output");

endmodule

bind fat_cluster_chain_walker_core fccw_checker u_fccw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
